>>> rtl/blpg_pkg.sv
`timescale 1ns / 1ps
package blpg_pkg;

    localparam int COORD_BITS = 13;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int DIM_BITS   = 12;
    localparam int COLOR_BITS = 16;
    localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_BITS   = 1;
    localparam int CNT_BITS   = 2;

    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PANEL_HEIGHT = 2'd1;

    localparam logic [DIM_BITS-1:0] PANEL_WIDTH_RST  = 12'd240;
    localparam logic [DIM_BITS-1:0] PANEL_HEIGHT_RST = 12'd320;

    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } panel_t;

    // classified command handed from front to back
    typedef struct packed {
        func_t                 func;
        coord_t                x0;
        coord_t                y0;
        coord_t                x1;
        coord_t                y1;
        delta_t                dx;
        delta_t                dy;
        logic                  sx_neg;
        logic                  sy_neg;
        err_t                  err;
        logic [COLOR_BITS-1:0] color;
    } cmd_t;

endpackage

>>> rtl/bresenham_line_pixel_generator.sv
// A beat accepted at the input is written into the queue, then popped into the result register and shown on m_valid.
// Throughput: one item per cycle while m_ready does not hold the output; the back end does one error update
// and one clip per cycle, and a two-entry queue plus the result register absorb output stalls.
// Reset (aresetn, synchronous, active low): queue and result register empty,
// no line active, panel 240 x 320.
`timescale 1ns / 1ps
module bresenham_line_pixel_generator
    import blpg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [DIM_BITS-1:0]      cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic [COORD_BITS-1:0]    s_start_x,
    input  logic [COORD_BITS-1:0]    s_start_y,
    input  logic [COORD_BITS-1:0]    s_end_x,
    input  logic [COORD_BITS-1:0]    s_end_y,
    input  logic [COLOR_BITS-1:0]    s_line_color,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [COORD_BITS-1:0]    m_pixel_x,
    output logic [COORD_BITS-1:0]    m_pixel_y,
    output logic [COLOR_BITS-1:0]    m_pixel_color,
    output logic                     m_on_screen,
    output logic                     m_last_pixel,
    output logic                     m_idle
);

    panel_t panel_reg, panel_next;
    logic   q_full;
    logic   q_empty;
    logic   q_push;
    logic   q_pop;
    cmd_t   q_in;
    cmd_t   q_out;

    always_comb begin
        panel_next = panel_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PANEL_WIDTH:  panel_next.width  = cfg_wdata;
                REG_PANEL_HEIGHT: panel_next.height = cfg_wdata;
                default:          panel_next        = panel_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            panel_reg.width  <= PANEL_WIDTH_RST;
            panel_reg.height <= PANEL_HEIGHT_RST;
        end else begin
            panel_reg <= panel_next;
        end
    end

    blpg_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_line_color (s_line_color),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_in)
    );

    blpg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    blpg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .panel         (panel_reg),
        .q_empty       (q_empty),
        .q_cmd         (q_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_on_screen   (m_on_screen),
        .m_last_pixel  (m_last_pixel),
        .m_idle        (m_idle)
    );

endmodule

>>> rtl/blpg_front.sv
`timescale 1ns / 1ps
module blpg_front
    import blpg_pkg::*;
(
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    input  logic [COLOR_BITS-1:0] s_line_color,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    logic signed [COORD_BITS:0] diff_x;
    logic signed [COORD_BITS:0] diff_y;
    logic        [COORD_BITS:0] mag_x;
    logic        [COORD_BITS:0] mag_y;
    delta_t                     dx;
    delta_t                     dy;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        diff_x = {s_end_x[COORD_BITS-1], s_end_x} - {s_start_x[COORD_BITS-1], s_start_x};
        diff_y = {s_end_y[COORD_BITS-1], s_end_y} - {s_start_y[COORD_BITS-1], s_start_y};
        mag_x  = diff_x[COORD_BITS] ? $unsigned(-diff_x) : $unsigned(diff_x);
        mag_y  = diff_y[COORD_BITS] ? $unsigned(-diff_y) : $unsigned(diff_y);
        dx     = mag_x[COORD_BITS-1:0];
        dy     = mag_y[COORD_BITS-1:0];

        q_cmd.func   = func_t'(s_func);
        q_cmd.x0     = coord_t'(s_start_x);
        q_cmd.y0     = coord_t'(s_start_y);
        q_cmd.x1     = coord_t'(s_end_x);
        q_cmd.y1     = coord_t'(s_end_y);
        q_cmd.dx     = dx;
        q_cmd.dy     = dy;
        // step is negative unless start < end
        q_cmd.sx_neg = diff_x[COORD_BITS] || (diff_x == '0);
        q_cmd.sy_neg = diff_y[COORD_BITS] || (diff_y == '0);
        if (dx > dy) begin
            q_cmd.err = err_t'(dx >> 1);
        end else begin
            q_cmd.err = -err_t'(dy >> 1);
        end
        q_cmd.color  = s_line_color;
    end

endmodule

>>> rtl/blpg_fifo.sv
`timescale 1ns / 1ps
module blpg_fifo
    import blpg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t pop_data,
    output logic full,
    output logic empty
);

    cmd_t                mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_BITS'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/blpg_back.sv
`timescale 1ns / 1ps
module blpg_back
    import blpg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  panel_t                panel,
    input  logic                  q_empty,
    input  cmd_t                  q_cmd,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_BITS-1:0] m_pixel_color,
    output logic                  m_on_screen,
    output logic                  m_last_pixel,
    output logic                  m_idle
);

    // line state
    coord_t                cur_x_reg, cur_x_next;
    coord_t                cur_y_reg, cur_y_next;
    coord_t                tgt_x_reg, tgt_x_next;
    coord_t                tgt_y_reg, tgt_y_next;
    delta_t                dx_reg, dx_next;
    delta_t                dy_reg, dy_next;
    logic                  sx_neg_reg, sx_neg_next;
    logic                  sy_neg_reg, sy_neg_next;
    err_t                  err_reg, err_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic                  active_reg, active_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    coord_t                px_reg, px_next;
    coord_t                py_reg, py_next;
    logic [COLOR_BITS-1:0] pc_reg, pc_next;
    logic                  on_reg, on_next;
    logic                  last_reg, last_next;
    logic                  idle_reg, idle_next;

    logic   is_start;
    logic   no_line;
    logic   go_x;
    logic   go_y;
    err_t   dx_e;
    err_t   dy_e;
    coord_t step_x;
    coord_t step_y;
    coord_t adv_x;
    coord_t adv_y;
    coord_t pos_x;
    coord_t pos_y;
    coord_t end_x;
    coord_t end_y;
    logic   hit_end;
    logic   visible;

    assign q_pop    = !q_empty && (!m_valid_reg || m_ready);
    assign is_start = (q_cmd.func == FUNC_START);
    assign no_line  = !is_start && !active_reg;

    always_comb begin
        dx_e    = err_t'(dx_reg);
        dy_e    = err_t'(dy_reg);
        go_x    = err_reg > -dx_e;
        go_y    = err_reg < dy_e;
        step_x  = sx_neg_reg ? coord_t'(-1) : coord_t'(1);
        step_y  = sy_neg_reg ? coord_t'(-1) : coord_t'(1);
        adv_x   = go_x ? cur_x_reg + step_x : cur_x_reg;
        adv_y   = go_y ? cur_y_reg + step_y : cur_y_reg;
        pos_x   = is_start ? q_cmd.x0 : adv_x;
        pos_y   = is_start ? q_cmd.y0 : adv_y;
        end_x   = is_start ? q_cmd.x1 : tgt_x_reg;
        end_y   = is_start ? q_cmd.y1 : tgt_y_reg;
        hit_end = (pos_x == end_x) && (pos_y == end_y);
        visible = !pos_x[COORD_BITS-1] && !pos_y[COORD_BITS-1]
                  && (CMP_BITS'($unsigned(pos_x)) < CMP_BITS'(panel.width))
                  && (CMP_BITS'($unsigned(pos_y)) < CMP_BITS'(panel.height));
    end

    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        err_next    = err_reg;
        color_next  = color_reg;
        active_next = active_reg;
        if (q_pop && is_start) begin
            cur_x_next  = q_cmd.x0;
            cur_y_next  = q_cmd.y0;
            tgt_x_next  = q_cmd.x1;
            tgt_y_next  = q_cmd.y1;
            dx_next     = q_cmd.dx;
            dy_next     = q_cmd.dy;
            sx_neg_next = q_cmd.sx_neg;
            sy_neg_next = q_cmd.sy_neg;
            err_next    = q_cmd.err;
            color_next  = q_cmd.color;
            active_next = !hit_end;
        end else if (q_pop && !no_line) begin
            cur_x_next  = adv_x;
            cur_y_next  = adv_y;
            err_next    = err_reg - (go_x ? dy_e : '0) + (go_y ? dx_e : '0);
            active_next = !hit_end;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pc_next      = pc_reg;
        on_next      = on_reg;
        last_next    = last_reg;
        idle_next    = idle_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
            if (no_line) begin
                px_next   = '0;
                py_next   = '0;
                pc_next   = '0;
                on_next   = 1'b0;
                last_next = 1'b0;
                idle_next = 1'b1;
            end else begin
                px_next   = pos_x;
                py_next   = pos_y;
                pc_next   = is_start ? q_cmd.color : color_reg;
                on_next   = visible;
                last_next = hit_end;
                idle_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        pc_reg     <= pc_next;
        on_reg     <= on_next;
        last_reg   <= last_next;
        idle_reg   <= idle_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            tgt_x_reg   <= '0;
            tgt_y_reg   <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            sx_neg_reg  <= 1'b0;
            sy_neg_reg  <= 1'b0;
            err_reg     <= '0;
            color_reg   <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            tgt_x_reg   <= tgt_x_next;
            tgt_y_reg   <= tgt_y_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            sx_neg_reg  <= sx_neg_next;
            sy_neg_reg  <= sy_neg_next;
            err_reg     <= err_next;
            color_reg   <= color_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_color = pc_reg;
    assign m_on_screen   = on_reg;
    assign m_last_pixel  = last_reg;
    assign m_idle        = idle_reg;

    a_idle_beat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && idle_reg) |-> (px_reg == '0 && py_reg == '0 && pc_reg == '0
                                       && !on_reg && !last_reg))
        else $error("idle beat carries pixel data");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !no_line && hit_end) |=> !active_reg)
        else $error("line still active after last pixel");

    a_idle_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && no_line) |=> ($stable(cur_x_reg) && $stable(cur_y_reg)
                                && $stable(err_reg)))
        else $error("idle advance changed line state");

endmodule

>>> tb/line_pixel_checker.sv
`timescale 1ns / 1ps
module line_pixel_checker
    import blpg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [DIM_BITS-1:0]      cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_func,
    input  logic [COORD_BITS-1:0]    s_start_x,
    input  logic [COORD_BITS-1:0]    s_start_y,
    input  logic [COORD_BITS-1:0]    s_end_x,
    input  logic [COORD_BITS-1:0]    s_end_y,
    input  logic [COLOR_BITS-1:0]    s_line_color,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [COORD_BITS-1:0]    m_pixel_x,
    input  logic [COORD_BITS-1:0]    m_pixel_y,
    input  logic [COLOR_BITS-1:0]    m_pixel_color,
    input  logic                     m_on_screen,
    input  logic                     m_last_pixel,
    input  logic                     m_idle,
    output int                       mismatches,
    output int                       in_flight,
    output int                       beats_in,
    output int                       pixels_checked,
    output int                       idle_beats,
    output int                       line_ends,
    output int                       visible_pixels
);

    typedef struct packed {
        coord_t                x;
        coord_t                y;
        logic [COLOR_BITS-1:0] color;
        logic                  visible;
        logic                  last;
        logic                  idle;
    } pixel_beat_t;

    pixel_beat_t expected_pixels[$];

    logic [DIM_BITS-1:0]   width_q;
    logic [DIM_BITS-1:0]   height_q;
    coord_t                pos_x;
    coord_t                pos_y;
    coord_t                goal_x;
    coord_t                goal_y;
    delta_t                run_x;
    delta_t                run_y;
    logic                  neg_x;
    logic                  neg_y;
    err_t                  err_acc;
    logic [COLOR_BITS-1:0] color_q;
    logic                  drawing;

    int mism   = 0;
    int n_in   = 0;
    int n_seen = 0;
    int n_idle = 0;
    int n_last = 0;
    int n_vis  = 0;

    function automatic pixel_beat_t pixel_here();
        pixel_beat_t p;
        p.x       = pos_x;
        p.y       = pos_y;
        p.color   = color_q;
        p.visible = (int'(pos_x) >= 0) && (int'(pos_y) >= 0) &&
                    (int'(pos_x) < int'(width_q)) && (int'(pos_y) < int'(height_q));
        p.last    = (pos_x == goal_x) && (pos_y == goal_y);
        p.idle    = 1'b0;
        return p;
    endfunction

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("t=%0t pixel beat %0d: %s expected %0d, actual %0d",
                     $time, n_seen, field, want_v, got_v);
            mism++;
        end
    endtask

    always @(posedge aclk) begin : track
        int          x0, y0, x1, y1, dxi, dyi, e2, ei;
        pixel_beat_t want;
        if (!aresetn) begin
            expected_pixels.delete();
            width_q  = PANEL_WIDTH_RST;
            height_q = PANEL_HEIGHT_RST;
            pos_x    = '0;
            pos_y    = '0;
            goal_x   = '0;
            goal_y   = '0;
            run_x    = '0;
            run_y    = '0;
            neg_x    = 1'b0;
            neg_y    = 1'b0;
            err_acc  = '0;
            color_q  = '0;
            drawing  = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("t=%0t pixel beat with nothing expected: x=%0d y=%0d idle=%0b",
                             $time, coord_t'(m_pixel_x), coord_t'(m_pixel_y), m_idle);
                    mism++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", int'(want.x), int'(coord_t'(m_pixel_x)));
                    check_field("pixel_y", int'(want.y), int'(coord_t'(m_pixel_y)));
                    check_field("pixel_color", int'(want.color), int'(m_pixel_color));
                    check_field("on_screen", int'(want.visible), int'(m_on_screen));
                    check_field("last_pixel", int'(want.last), int'(m_last_pixel));
                    check_field("idle", int'(want.idle), int'(m_idle));
                    if (want.idle) n_idle++;
                    if (want.last) n_last++;
                    if (want.visible) n_vis++;
                end
                n_seen++;
            end

            if (s_valid && s_ready) begin
                n_in++;
                if (s_func == FUNC_START) begin
                    x0 = int'(coord_t'(s_start_x));
                    y0 = int'(coord_t'(s_start_y));
                    x1 = int'(coord_t'(s_end_x));
                    y1 = int'(coord_t'(s_end_y));
                    dxi = (x1 > x0) ? x1 - x0 : x0 - x1;
                    dyi = (y1 > y0) ? y1 - y0 : y0 - y1;
                    run_x   = delta_t'(dxi);
                    run_y   = delta_t'(dyi);
                    neg_x   = !(x0 < x1);
                    neg_y   = !(y0 < y1);
                    err_acc = err_t'((dxi > dyi) ? dxi / 2 : -(dyi / 2));
                    pos_x   = coord_t'(x0);
                    pos_y   = coord_t'(y0);
                    goal_x  = coord_t'(x1);
                    goal_y  = coord_t'(y1);
                    color_q = s_line_color;
                    want    = pixel_here();
                    drawing = !want.last;
                end else if (!drawing) begin
                    want      = '0;
                    want.idle = 1'b1;
                end else begin
                    dxi = int'(run_x);
                    dyi = int'(run_y);
                    e2  = int'(err_acc);
                    ei  = e2;
                    if (e2 > -dxi) begin
                        ei    = ei - dyi;
                        pos_x = coord_t'(int'(pos_x) + (neg_x ? -1 : 1));
                    end
                    if (e2 < dyi) begin
                        ei    = ei + dxi;
                        pos_y = coord_t'(int'(pos_y) + (neg_y ? -1 : 1));
                    end
                    err_acc = err_t'(ei);
                    want    = pixel_here();
                    drawing = !want.last;
                end
                expected_pixels.push_back(want);
            end

            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_PANEL_WIDTH:  width_q  = cfg_wdata;
                    REG_PANEL_HEIGHT: height_q = cfg_wdata;
                    default: ;
                endcase
            end
        end

        mismatches     <= mism;
        in_flight      <= expected_pixels.size();
        beats_in       <= n_in;
        pixels_checked <= n_seen;
        idle_beats     <= n_idle;
        line_ends      <= n_last;
        visible_pixels <= n_vis;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import blpg_pkg::*;

    localparam int CMIN            = -(1 << (COORD_BITS - 1));
    localparam int CMAX            = (1 << (COORD_BITS - 1)) - 1;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 257;
    localparam int HOLD_CYCLES     = 400;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_B = 2'd3;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [DIM_BITS-1:0]      cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_func;
    logic [COORD_BITS-1:0]    s_start_x;
    logic [COORD_BITS-1:0]    s_start_y;
    logic [COORD_BITS-1:0]    s_end_x;
    logic [COORD_BITS-1:0]    s_end_y;
    logic [COLOR_BITS-1:0]    s_line_color;
    logic                     m_valid;
    logic                     m_ready;
    logic [COORD_BITS-1:0]    m_pixel_x;
    logic [COORD_BITS-1:0]    m_pixel_y;
    logic [COLOR_BITS-1:0]    m_pixel_color;
    logic                     m_on_screen;
    logic                     m_last_pixel;
    logic                     m_idle;

    int mismatches, in_flight, beats_in, pixels_checked, idle_beats, line_ends, visible_pixels;

    int items_sent   = 0;
    int settings     = 1;
    int cur_w        = 240;
    int cur_h        = 320;
    bit calm         = 1'b0;
    bit hold_off_now = 1'b0;
    bit holding      = 1'b0;

    bresenham_line_pixel_generator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .s_line_color  (s_line_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_on_screen   (m_on_screen),
        .m_last_pixel  (m_last_pixel),
        .m_idle        (m_idle)
    );

    line_pixel_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .s_line_color   (s_line_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_color  (m_pixel_color),
        .m_on_screen    (m_on_screen),
        .m_last_pixel   (m_last_pixel),
        .m_idle         (m_idle),
        .mismatches     (mismatches),
        .in_flight      (in_flight),
        .beats_in       (beats_in),
        .pixels_checked (pixels_checked),
        .idle_beats     (idle_beats),
        .line_ends      (line_ends),
        .visible_pixels (visible_pixels)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < CMIN)
            return CMIN;
        if (v > CMAX)
            return CMAX;
        return v;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, (1 << COORD_BITS) - 1)) + CMIN;
    endfunction

    function automatic int near_coord(input int lim);
        return clamp_coord(int'($urandom_range(0, lim + 16)) - 8);
    endfunction

    task automatic send_beat(input func_t f, input int x0, input int y0,
                             input int x1, input int y1, input int c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_start_x    <= x0[COORD_BITS-1:0];
        s_start_y    <= y0[COORD_BITS-1:0];
        s_end_x      <= x1[COORD_BITS-1:0];
        s_end_y      <= y1[COORD_BITS-1:0];
        s_line_color <= c[COLOR_BITS-1:0];
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // endpoint fields carry noise on advances
    task automatic advance();
        send_beat(FUNC_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord(), $urandom);
    endtask

    task automatic draw_random_line();
        int x0, y0, x1, y1, span, dx, dy, steps, count, r;
        if ($urandom_range(0, 24) == 0)
            advance();
        x0 = ($urandom_range(0, 99) < 55) ? near_coord(cur_w) : any_coord();
        y0 = ($urandom_range(0, 99) < 55) ? near_coord(cur_h) : any_coord();
        r = $urandom_range(0, 99);
        span = (r < 88) ? 12 : (r < 98) ? 150 : (1 << COORD_BITS) - 1;
        dx = $urandom_range(0, span);
        dy = $urandom_range(0, span);
        r = $urandom_range(0, 9);
        if (r == 0)
            dx = 0;
        else if (r == 1)
            dy = 0;
        x1 = clamp_coord($urandom_range(0, 1) ? x0 - dx : x0 + dx);
        y1 = clamp_coord($urandom_range(0, 1) ? y0 - dy : y0 + dy);
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        steps = (dx > dy) ? dx : dy;
        r = $urandom_range(0, 99);
        if (r < 75)
            count = steps;
        else if (r < 88)
            count = steps + $urandom_range(1, 2);
        else
            count = $urandom_range(0, steps);
        if (count > 40)
            count = 40;
        send_beat(FUNC_START, x0, y0, x1, y1, $urandom);
        repeat (count) advance();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
    endtask

    task automatic cfg_burst(input int w, input int h, input logic [CFG_ADDR_BITS-1:0] spare);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_PANEL_WIDTH;
        cfg_wdata <= w[DIM_BITS-1:0];
        @(posedge aclk);
        cfg_addr  <= spare;
        cfg_wdata <= DIM_BITS'($urandom);
        @(posedge aclk);
        cfg_addr  <= REG_PANEL_HEIGHT;
        cfg_wdata <= h[DIM_BITS-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_w = w;
        cur_h = h;
        settings++;
    endtask

    // receiver: random back-pressure, plus one long hold on request
    initial begin : receiver
        int run, gap;
        m_ready = 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (hold_off_now) begin
                holding = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holding = 1'b0;
            end else begin
                run = $urandom_range(1, 24);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int p, goal;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = REG_PANEL_WIDTH;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_func       = FUNC_START;
        s_start_x    = '0;
        s_start_y    = '0;
        s_end_x      = '0;
        s_end_y      = '0;
        s_line_color = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, reset panel size
        advance();
        send_beat(FUNC_START, 5, 5, 5, 5, 16'hFFFF);
        advance();
        send_beat(FUNC_START, 0, 0, 3, 1, 16'h0000);
        repeat (4) advance();
        send_beat(FUNC_START, CMIN, CMIN, CMAX, CMAX, 16'hA5A5);
        repeat (2) advance();
        send_beat(FUNC_START, CMAX, CMAX, CMIN, CMIN, 16'h5A5A);
        repeat (2) advance();
        send_beat(FUNC_START, CMAX, CMIN, CMIN, CMIN + 6, 16'hF800);
        advance();
        send_beat(FUNC_START, 0, CMIN, 2, CMAX, 16'h07E0);
        advance();
        send_beat(FUNC_START, 239, 319, 240, 320, 16'h001F);
        advance();
        send_beat(FUNC_START, -1, 0, 0, -1, 16'h8410);
        advance();

        for (p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: cfg_burst(4095, 4095, REG_SPARE_A);
                1: cfg_burst(1, 1, REG_SPARE_B);
                2: cfg_burst(0, 320, REG_SPARE_A);
                3: cfg_burst(240, 0, REG_SPARE_B);
                4: cfg_burst($urandom_range(1, 4095), $urandom_range(1, 4095), REG_SPARE_A);
                5: cfg_burst($urandom_range(1, 64), $urandom_range(1, 64), REG_SPARE_B);
                default: cfg_burst(240, 320, REG_SPARE_A);
            endcase
            if (p == PHASES - 1) begin
                // fill the block while the receiver is held off
                hold_off_now = 1'b1;
                while (!holding) @(posedge aclk);
                hold_off_now = 1'b0;
                calm = 1'b1;
                goal = items_sent + 30;
                while (items_sent < goal)
                    draw_random_line();
            end
            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal) begin
                calm = ($urandom_range(0, 7) == 0);
                draw_random_line();
            end
            calm = 1'b0;
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Ran %0d input beats over %0d panel settings (zero, one and full-size included).",
                 beats_in, settings);
        $display("Checked %0d pixel beats: %0d line ends, %0d idle, %0d on screen.",
                 pixels_checked, line_ends, idle_beats, visible_pixels);
        if (mismatches == 0 && in_flight == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d pixels still expected", mismatches, in_flight);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("Timeout at t=%0t with %0d pixels still expected", $time, in_flight);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
